// ===== rtl/tmsa_pkg.sv =====
// Shared types, constants and helpers for the trimmed-mean sample averager.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tmsa_pkg;

    localparam int CHANNELS  = 2;
    localparam int CH_W      = 1;
    localparam int CH_AW     = $clog2(CHANNELS);
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 18;
    localparam int CNT_W     = 7;
    localparam int DIVR_W    = 6;
    localparam int DIV_STEPS = SUM_W;
    localparam int DSTEP_W   = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(10);
    localparam logic [CNT_W-1:0] WIN_MIN   = CNT_W'(3);
    localparam logic [CNT_W-1:0] WIN_MAX   = CNT_W'(64);
    localparam logic [CNT_W-1:0] TRIM_CNT  = CNT_W'(2);

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic [CH_W-1:0]     result_channel;
        logic [SAMPLE_W-1:0] average;
    } t_out_res;

    typedef struct packed {
        logic [SUM_W-1:0]    running_sum;
        logic [SAMPLE_W-1:0] window_min;
        logic [SAMPLE_W-1:0] window_max;
        logic [CNT_W-1:0]    samples_seen;
    } t_win_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (n < WIN_MIN) begin
            n = WIN_MIN;
        end else if (n > WIN_MAX) begin
            n = WIN_MAX;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tmsa_win_mem.sv =====
// Per-channel window memory: synchronous write, registered read.
// Entries never written since reset read as zero. Depends on tmsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmsa_win_mem (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_rd_en,
    input  wire  [tmsa_pkg::CH_AW-1:0]     i_rd_addr,
    output tmsa_pkg::t_win_entry           o_rd_data,
    input  wire                            i_wr_en,
    input  wire  [tmsa_pkg::CH_AW-1:0]     i_wr_addr,
    input  tmsa_pkg::t_win_entry           i_wr_data
);
    import tmsa_pkg::*;

    t_win_entry            r_mem [CHANNELS];
    logic [CHANNELS-1:0]   r_valid;
    t_win_entry            r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && i_wr_en))
        else $error("window memory read and write in the same cycle");

    a_wr_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_valid[$past(i_wr_addr)])
        else $error("written entry not marked valid");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_valid == '0 && !r_rd_vld))
        else $error("reset did not clear entry valid bits");

endmodule

`default_nettype wire

// ===== rtl/tmsa_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the trimmed window sum.
// Depends on tmsa_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module tmsa_divider (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire  [tmsa_pkg::SUM_W-1:0]      i_dividend,
    input  wire  [tmsa_pkg::DIVR_W-1:0]     i_divisor,
    output tmsa_pkg::t_div_stat             o_stat,
    output logic [tmsa_pkg::SUM_W-1:0]      o_quotient
);
    import tmsa_pkg::*;

    logic [SUM_W-1:0]   r_quo;
    logic [DIVR_W-1:0]  r_rem;
    logic [DIVR_W-1:0]  r_div;
    logic [DSTEP_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIVR_W:0]    w_trial;
    logic [DIVR_W:0]    w_diff;
    logic               w_ge;
    logic               w_last;

    always_comb begin
        w_trial = {r_rem, r_quo[SUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = w_trial >= {1'b0, r_div};
        w_last  = r_cnt == DSTEP_W'(DIV_STEPS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVR_W-1:0] : w_trial[DIVR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DSTEP_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

    a_nonzero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> i_divisor != '0)
        else $error("divide started with zero divisor");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_last && !i_start) |=> (r_done && !r_busy))
        else $error("divider did not finish after last step");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

endmodule

`default_nettype wire

// ===== rtl/trimmed_mean_sample_averager_top.sv =====
// Trimmed-mean sample averager: a request that leaves its channel's window open passes
// through accept, window memory read, update and write back. A request that closes
// the window also runs the 18-step iterative divider, then waits for the output
// register to drain before its result is loaded and presented.
// Ready is low between requests; a finished result waits in the output register while
// the next request is taken. No clearing pass after reset.
// Depends on tmsa_pkg, tmsa_win_mem and tmsa_divider.
`timescale 1ns / 1ps
`default_nettype none

module trimmed_mean_sample_averager_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  tmsa_pkg::t_in_req               i_in_req,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output tmsa_pkg::t_out_res              o_out_res,
    input  wire                             i_cfg_we,
    input  wire  [tmsa_pkg::CNT_W-1:0]      i_cfg_wdata
);
    import tmsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIV    = 4'b0100,
        S_WAIT   = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_window_count;
    t_in_req            r_req;
    logic [CH_W-1:0]    r_ch;
    logic               r_out_valid;
    t_out_res           r_out_res;

    t_win_entry         w_rd;
    t_win_entry         w_upd;
    t_win_entry         w_wr_data;
    logic               w_accept;
    logic               w_complete;
    logic               w_wr_en;
    logic               w_div_start;
    logic [SUM_W-1:0]   w_trimmed;
    logic [DIVR_W-1:0]  w_divisor;
    logic [CNT_W-1:0]   w_divisor_full;
    logic               w_out_load;
    t_div_stat          w_div_stat;
    logic [SUM_W-1:0]   w_quotient;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = r_state == S_IDLE;

    tmsa_win_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_in_req.channel[CH_AW-1:0]),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_req.channel[CH_AW-1:0]),
        .i_wr_data (w_wr_data)
    );

    always_comb begin
        w_upd = w_rd;
        if (w_rd.samples_seen == '0) begin
            w_upd.window_min = r_req.sample;
            w_upd.window_max = r_req.sample;
        end else if (r_req.sample < w_rd.window_min) begin
            w_upd.window_min = r_req.sample;
        end else if (r_req.sample > w_rd.window_max) begin
            w_upd.window_max = r_req.sample;
        end
        w_upd.running_sum  = w_rd.running_sum + SUM_W'(r_req.sample);
        w_upd.samples_seen = w_rd.samples_seen + CNT_W'(1);

        w_complete     = w_upd.samples_seen >= eff_window(r_window_count);
        w_trimmed      = w_upd.running_sum - SUM_W'(w_upd.window_min)
                         - SUM_W'(w_upd.window_max);
        w_divisor_full = w_upd.samples_seen - TRIM_CNT;
        w_divisor      = w_divisor_full[DIVR_W-1:0];

        w_wr_en     = r_state == S_UPDATE;
        w_wr_data   = w_complete ? '0 : w_upd;
        w_div_start = w_wr_en && w_complete;
        w_out_load  = (r_state == S_WAIT) && (!r_out_valid || i_out_ready);
    end

    tmsa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_trimmed),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = w_complete ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_req;
        end
        if (w_div_start) begin
            r_ch <= r_req.channel;
        end
        if (w_out_load) begin
            r_out_res.result_channel <= r_ch;
            r_out_res.average        <= w_quotient[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window_count <= WIN_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_window_count <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_UPDATE)
        else $error("accepted request not followed by update");

    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_div_stat.busy)
        else $error("divider busy while taking a new request");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result load did not present output");

endmodule

`default_nettype wire

// ===== tb/trimmed_mean_sample_averager_top_tb.sv =====
// Testbench for trimmed_mean_sample_averager_top: directed and random sample requests, a
// per-channel window predictor and an in-order result scoreboard, with sender and receiver idling.
// Depends on tmsa_pkg and the averager RTL.
`timescale 1ns / 1ps

import tmsa_pkg::*;

function automatic int unsigned window_limit(input logic [CNT_W-1:0] setting);
    int unsigned n;
    n = setting;
    if (n < WIN_MIN) begin
        n = WIN_MIN;
    end else if (n > WIN_MAX) begin
        n = WIN_MAX;
    end
    return n;
endfunction

class trim_avg_board;
    logic [CNT_W-1:0]    window_reg;
    logic [SUM_W-1:0]    sum_acc    [CHANNELS];
    logic [SAMPLE_W-1:0] lo_seen    [CHANNELS];
    logic [SAMPLE_W-1:0] hi_seen    [CHANNELS];
    logic [CNT_W-1:0]    count_seen [CHANNELS];
    t_out_res            averages_due[$];
    int                  errors;

    function new();
        window_reg = WIN_RESET;
        errors = 0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            sum_acc[ch] = '0;
            lo_seen[ch] = '0;
            hi_seen[ch] = '0;
            count_seen[ch] = '0;
        end
    endfunction

    function int pending();
        return averages_due.size();
    endfunction

    function void note_sample(input t_in_req req);
        int unsigned ch;
        int unsigned n;
        int unsigned trimmed;
        logic [SAMPLE_W-1:0] s;
        t_out_res want;
        ch = req.channel;
        s = req.sample;
        if (ch >= CHANNELS) begin
            return;
        end
        if (count_seen[ch] == 0) begin
            lo_seen[ch] = s;
            hi_seen[ch] = s;
        end else if (s < lo_seen[ch]) begin
            lo_seen[ch] = s;
        end else if (s > hi_seen[ch]) begin
            hi_seen[ch] = s;
        end
        sum_acc[ch] = sum_acc[ch] + SUM_W'(s);
        count_seen[ch] = count_seen[ch] + 1'b1;
        n = count_seen[ch];
        if (n < window_limit(window_reg)) begin
            return;
        end
        trimmed = int'(sum_acc[ch]) - int'(lo_seen[ch]) - int'(hi_seen[ch]);
        want.result_channel = CH_W'(ch);
        want.average = SAMPLE_W'(trimmed / (n - 2));
        averages_due.push_back(want);
        sum_acc[ch] = '0;
        lo_seen[ch] = '0;
        hi_seen[ch] = '0;
        count_seen[ch] = '0;
    endfunction

    function void check_average(input t_out_res got);
        t_out_res want;
        if (averages_due.size() == 0) begin
            $error("unexpected result: result_channel %0d average %0d",
                   got.result_channel, got.average);
            errors++;
            return;
        end
        want = averages_due.pop_front();
        if (got.result_channel !== want.result_channel) begin
            $error("result_channel: expected %0d, actual %0d",
                   want.result_channel, got.result_channel);
            errors++;
        end
        if (got.average !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, got.average);
            errors++;
        end
    endfunction
endclass

module trimmed_mean_sample_averager_top_tb;

    localparam int RANDOM_ITEMS = 700;
    localparam int SETTLE       = 30;
    localparam int QUIET_LIMIT  = 2000;

    typedef enum {RCV_OPEN, RCV_RANDOM, RCV_SPARSE, RCV_CHOKED} rcv_mode_e;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_req          i_in_req = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_res         o_out_res;
    logic             i_cfg_we = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;

    trim_avg_board board;
    int unsigned   burst_left = 0;
    int unsigned   random_sent = 0;
    rcv_mode_e     rcv_mode = RCV_OPEN;
    int unsigned   rcv_left = 0;
    int unsigned   rcv_tick = 0;

    trimmed_mean_sample_averager_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                board.window_reg = i_cfg_wdata;
            end
            if (i_in_valid && o_in_ready) begin
                board.note_sample(i_in_req);
            end
            if (o_out_valid && i_out_ready) begin
                board.check_average(o_out_res);
            end
        end
    end

    always @(posedge i_clk) begin
        if (rcv_left == 0) begin
            rcv_mode = rcv_mode_e'($urandom_range(0, 3));
            rcv_left = $urandom_range(10, 300);
        end
        rcv_left--;
        rcv_tick++;
        case (rcv_mode)
            RCV_OPEN:   i_out_ready <= 1'b1;
            RCV_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
            RCV_SPARSE: i_out_ready <= (rcv_tick % 8 == 0);
            default:    i_out_ready <= (rcv_tick % 24 == 0);
        endcase
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return SAMPLE_W'($urandom_range(2000, 2100));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(input int unsigned ch, input logic [SAMPLE_W-1:0] s);
        t_in_req req;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req.channel = CH_W'(ch);
        req.sample = s;
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [CNT_W-1:0] setting);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= setting;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] forced_windows [6];
        logic [CNT_W-1:0] setting;
        int unsigned      phase_no;
        int unsigned      span;
        int unsigned      lim;
        forced_windows = '{7'd64, 7'd127, 7'd1, 7'd65, 7'd4, 7'd63};
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // partial windows at the reset length, then lower it under them
        send_sample(0, 12'd50);
        send_sample(1, 12'd1000);
        send_sample(0, 12'd7);
        send_sample(1, 12'd1000);
        send_sample(0, 12'd3000);
        send_sample(1, 12'd999);
        send_sample(0, 12'd200);
        reconfigure(7'd3);
        send_sample(0, 12'd60);
        send_sample(1, 12'd4095);

        reconfigure(7'd0);
        for (int k = 0; k < 3; k++) begin
            send_sample(0, 12'd4095);
            send_sample(1, 12'd0);
        end
        reconfigure(7'd2);
        for (int k = 0; k < 3; k++) begin
            send_sample(0, SAMPLE_W'(9 - k));
            send_sample(1, SAMPLE_W'(1 + k));
        end

        phase_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase_no < 6) begin
                setting = forced_windows[phase_no];
            end else begin
                case ($urandom_range(0, 7))
                    0:       setting = CNT_W'($urandom_range(0, 2));
                    1:       setting = CNT_W'($urandom_range(13, 127));
                    default: setting = CNT_W'($urandom_range(3, 12));
                endcase
            end
            phase_no++;
            reconfigure(setting);
            lim = window_limit(setting);
            span = $urandom_range(2 * lim + 10, 3 * lim + 30);
            for (int k = 0; k < span && random_sent < RANDOM_ITEMS; k++) begin
                send_sample($urandom_range(0, 1), pick_sample());
                random_sent++;
                if ($urandom_range(0, 79) == 0) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d expected results never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
